// ===== src/lnrast_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lnrast_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned BADDR_W  = 14;
  localparam int unsigned DATA_W   = 8;
  // error term spans about -2047..2047 plus one step of either sign
  localparam int unsigned ERR_W    = 14;

  localparam logic [DATA_W-1:0] PIXEL_MSB = 8'h80;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef struct packed {
    logic load;         // latch the command fields, reset clear counter and result
    logic clr_step;     // zero one bitmap byte and advance
    logic pix_rd;       // read the byte under the current pixel, step the line
    logic pix_wr;       // write back the merged byte
    logic rd_issue;     // read the addressed byte for a read command
    logic res_capture;  // take the RAM read data as result
    logic res_load;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;     // clear counter sits on the last byte
    logic line_last;    // pixel just read is the end point
    logic rd_in_range;  // read address lies inside the bitmap
  } sts_t;

endpackage

`default_nettype wire

// ===== src/lnrast_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnrast_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 9600,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/lnrast_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnrast_dp #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  lnrast_pkg::cmd_t                        cmd_i,
  output lnrast_pkg::sts_t                        sts_o,
  input  logic signed [lnrast_pkg::COORD_W-1:0]   start_x_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0]   start_y_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0]   end_x_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0]   end_y_i,
  input  logic        [lnrast_pkg::BADDR_W-1:0]   byte_address_i,
  output logic        [lnrast_pkg::DATA_W-1:0]    read_data_o
);

  import lnrast_pkg::*;

  localparam int ROW_BYTES    = (SCREEN_WIDTH + 7) / 8;
  localparam int BITMAP_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AddrW        = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int MulW         = (COORD_W - 1) + $clog2(ROW_BYTES + 1);

  logic signed [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
  logic signed [COORD_W-1:0] x_d, y_d;
  logic signed [ERR_W-1:0]   dx_q, dy_q, err_q, err_d;
  logic signed [ERR_W-1:0]   dx_init, dy_init, err_init;
  logic signed [COORD_W:0]   dif_x, dif_y, mag_x, mag_y;
  logic                      sx_q, sy_q;
  logic                      step_x, step_y;
  logic                      last_q;
  logic                      on_screen;
  logic [MulW-1:0]           row_base;
  logic [AddrW-1:0]          pix_addr;
  logic [DATA_W-1:0]         pix_mask;
  logic [AddrW-1:0]          wr_addr_q;
  logic [DATA_W-1:0]         mask_q;
  logic [AddrW-1:0]          clr_q;
  logic [BADDR_W-1:0]        baddr_q;
  logic [DATA_W-1:0]         res_q;
  logic [DATA_W-1:0]         out_q;
  logic                      ram_we, ram_re;
  logic [AddrW-1:0]          ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;

  // line setup from the incoming command
  assign dif_x    = {end_x_i[COORD_W-1], end_x_i} - {start_x_i[COORD_W-1], start_x_i};
  assign dif_y    = {end_y_i[COORD_W-1], end_y_i} - {start_y_i[COORD_W-1], start_y_i};
  assign mag_x    = dif_x[COORD_W] ? -dif_x : dif_x;
  assign mag_y    = dif_y[COORD_W] ? -dif_y : dif_y;
  assign dx_init  = ERR_W'(mag_x);
  assign dy_init  = ERR_W'(mag_y);
  assign err_init = (dx_init > dy_init) ? (dx_init >>> 1) : -(dy_init >>> 1);

  // one Bresenham step
  assign step_x = err_q > -dx_q;
  assign step_y = err_q < dy_q;
  assign err_d  = err_q - (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
  assign x_d    = step_x ? (sx_q ? x_q + 11'sd1 : x_q - 11'sd1) : x_q;
  assign y_d    = step_y ? (sy_q ? y_q + 11'sd1 : y_q - 11'sd1) : y_q;

  // clip and locate the current pixel
  assign on_screen = !x_q[COORD_W-1] && !y_q[COORD_W-1]
                  && ({1'b0, x_q[COORD_W-2:0]} < COORD_W'(SCREEN_WIDTH))
                  && ({1'b0, y_q[COORD_W-2:0]} < COORD_W'(SCREEN_HEIGHT));
  assign row_base  = MulW'(y_q[COORD_W-2:0]) * MulW'(ROW_BYTES);
  assign pix_addr  = AddrW'(row_base + MulW'(x_q[COORD_W-2:3]));
  assign pix_mask  = PIXEL_MSB >> x_q[2:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= start_x_i;
      y_q   <= start_y_i;
      xe_q  <= end_x_i;
      ye_q  <= end_y_i;
      dx_q  <= dx_init;
      dy_q  <= dy_init;
      err_q <= err_init;
      sx_q  <= start_x_i < end_x_i;
      sy_q  <= start_y_i < end_y_i;
      baddr_q <= byte_address_i;
    end else if (cmd_i.pix_rd) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_rd) begin
      wr_addr_q <= pix_addr;
      mask_q    <= on_screen ? pix_mask : '0;
      last_q    <= (x_q == xe_q) && (y_q == ye_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.load) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= '0;
    end else if (cmd_i.res_capture) begin
      res_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q <= res_q;
    end
  end

  // RAM ports: clear sweep or pixel merge on write, pixel or read command on read
  assign ram_we    = cmd_i.clr_step || (cmd_i.pix_wr && (mask_q != '0));
  assign ram_waddr = cmd_i.clr_step ? clr_q : wr_addr_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : (ram_rdata | mask_q);
  assign ram_re    = cmd_i.pix_rd || cmd_i.rd_issue;
  assign ram_raddr = cmd_i.rd_issue ? AddrW'(baddr_q) : pix_addr;

  lnrast_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.clr_last    = clr_q == AddrW'(BITMAP_BYTES - 1);
  assign sts_o.line_last   = last_q;
  assign sts_o.rd_in_range = 32'(baddr_q) < 32'(BITMAP_BYTES);
  assign read_data_o       = out_q;

endmodule

`default_nettype wire

// ===== src/lnrast_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnrast_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lnrast_pkg::FUNC_W-1:0]     func_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lnrast_pkg::cmd_t                  cmd_o,
  input  lnrast_pkg::sts_t                  sts_i
);

  import lnrast_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CLEAR   = 7'b0000010,
    S_PLOT_RD = 7'b0000100,
    S_PLOT_WR = 7'b0001000,
    S_READ    = 7'b0010000,
    S_RD_WAIT = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (func_i)
            FUNC_CLEAR: state_d = S_CLEAR;
            FUNC_DRAW:  state_d = S_PLOT_RD;
            FUNC_READ:  state_d = S_READ;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_PLOT_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = S_PLOT_WR;
      end
      S_PLOT_WR: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = sts_i.line_last ? S_DONE : S_PLOT_RD;
      end
      S_READ: begin
        if (sts_i.rd_in_range) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RD_WAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_WAIT: begin
        cmd_o.res_capture = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.res_load)
    else $error("result loaded over a stalled result");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLOT_WR && sts_i.line_last) |=> state_q == S_DONE)
    else $error("line did not finish after its end point");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && sts_i.clr_last) |=> state_q == S_DONE)
    else $error("clear sweep did not stop at the last byte");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("output valid raised outside of command completion");

endmodule

`default_nettype wire

// ===== src/line_rasterizer_1bpp_core.sv =====
// One-bit-per-pixel line rasterizer with an on-chip bitmap of
// SCREEN_WIDTH x SCREEN_HEIGHT pixels, eight pixels per byte, leftmost pixel
// in bit 7, rows of (SCREEN_WIDTH+7)/8 bytes.
// Input channel (in_valid_i / in_stall_o): one command item per handshake,
// func_i selects clear, draw line or read byte; unused fields are ignored.
// Output channel (out_valid_o / out_stall_i): exactly one result item per
// command; read_data_o carries the byte for a read and zero otherwise.
// Steps of each command, from the accepting edge to out_valid_o:
//   clear : one zero write per bitmap byte, then the result
//   draw  : max(dx,dy)+1 stepped pixels, each a read then a merge on the single
//           RAM write port; off-screen pixels are stepped the same way and not
//           written
//   read  : one RAM read in range, no RAM read for an address past the bitmap
// One command is in work at a time; in_stall_o is high until it completes.
// The output register parts the two sides: the next command is accepted
// while a result still waits on a stalled receiver, and that command then
// holds in its final cycle until the waiting result is taken.
// Reset clears the control state and the clear counter only; bitmap contents
// are undefined until the first clear command.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_1bpp_core #(
  parameter int unsigned SCREEN_WIDTH  = lnrast_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = lnrast_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [lnrast_pkg::FUNC_W-1:0]  func_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [lnrast_pkg::COORD_W-1:0] end_y_i,
  input  logic        [lnrast_pkg::BADDR_W-1:0] byte_address_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [lnrast_pkg::DATA_W-1:0]  read_data_o
);

  import lnrast_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the command and walks clear, draw and read
  lnrast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // line stepper, clip, address math, bitmap RAM and result registers
  lnrast_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .byte_address_i (byte_address_i),
    .read_data_o    (read_data_o)
  );

endmodule

`default_nettype wire
